[rtl/mcfp_pkg.sv]
package mcfp_pkg;

  localparam int MCFP_BUFFER_BYTES = 256;
  localparam logic [8:0] MCFP_BUFFER_SIZE_RST = 9'd256;

  // func codes on in_tuser
  localparam logic [1:0] FN_BYTE    = 2'd0;
  localparam logic [1:0] FN_TIMEOUT = 2'd1;
  localparam logic [1:0] FN_READ    = 2'd2;

  // frame kind on out_tuser
  localparam logic [1:0] FK_NONE    = 2'd0;
  localparam logic [1:0] FK_VALID   = 2'd1;
  localparam logic [1:0] FK_FOREIGN = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BIG    = 2'd1;
  localparam logic [1:0] ERR_HEADER = 2'd2;
  localparam logic [1:0] ERR_CRC    = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_LT     = 8'h3C;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR_M   = 3'd1,
    PH_HDR_DIR = 3'd2,
    PH_LEN     = 3'd3,
    PH_CMD     = 3'd4,
    PH_DATA    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic [1:0] error_code;
    logic       error_is_new;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] passed_byte;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [8:0] idx;
    logic [7:0] data;
  } wr_req_t;

endpackage

[rtl/mspv1_command_frame_parser_core.sv]
// MSPv1 command frame parser. Takes one item per cycle on the in_ channel while in_tready is
// high: a received byte, a receive timeout or a payload read. Every item gives exactly one
// result, which passes first through the parse stage, where the frame state is updated and
// the payload store is written or read, and then through the output register, which takes
// the registered read of the payload memory. The payload of the last frame stays in memory
// and is read back by index; indexes at or beyond BUFFER_BYTES read as zero. buffer_size may
// only be written while no item is in flight.
module mspv1_command_frame_parser_core
  import mcfp_pkg::*;
#(
  parameter int BUFFER_BYTES = MCFP_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte, payload_index
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  // error_code, error_is_new, command, payload_length, passed_byte, read_byte, zero fill
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser,  // frame_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // buffer_size
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int RW = (AW > 8) ? AW : 8;
  localparam int WW = (AW > 9) ? AW : 9;

  logic [8:0] buffer_size_r;
  logic       in_xfer;
  logic       s1_adv;
  logic       s1_valid_r;
  result_t    s1_res_r;
  logic       s1_rd_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic [7:0] out_rd_byte_r;

  result_t    res;
  wr_req_t    wr;
  logic       rd_en;
  logic       rd_in_range;
  logic [RW-1:0] rd_wide;
  logic [WW-1:0] wr_wide;
  logic [7:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= MCFP_BUFFER_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      buffer_size_r <= cfg_data;
    end
  end

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  mcfp_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .func        (in_tuser),
    .rx_byte     (in_tdata[7:0]),
    .buffer_size (buffer_size_r),
    .res         (res),
    .wr          (wr)
  );

  assign rd_in_range = (32'(in_tdata[15:8]) < BUFFER_BYTES);
  assign rd_en       = in_xfer && (in_tuser == FN_READ) && rd_in_range;
  assign rd_wide     = RW'(in_tdata[15:8]);
  assign wr_wide     = WW'(wr.idx);

  // reads never share a cycle with a write, so no bypass is needed
  mcfp_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr_wide[AW-1:0]),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_wide[AW-1:0]),
    .rdata (ram_rdata)
  );

  // parse stage; ram_rdata holds while this stage is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_res_r <= res;
      s1_rd_r  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_res_r     <= s1_res_r;
      out_rd_byte_r <= s1_rd_r ? ram_rdata : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.frame_kind;
  assign out_tdata  = {5'd0, out_rd_byte_r, out_res_r.passed_byte,
                       out_res_r.payload_length, out_res_r.command,
                       out_res_r.error_is_new, out_res_r.error_code};

  a_valid_no_error : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == FK_VALID |-> out_tdata[2:0] == 3'd0)
    else $error("completed frame carries an error");

  a_new_needs_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] != ERR_NONE)
    else $error("new-error flag without an error code");

  a_foreign_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == FK_FOREIGN |-> out_tdata[18:0] == 19'd0
      && out_tdata[34:27] == 8'd0)
    else $error("foreign byte result carries frame fields");

  a_stall_holds_read : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> $stable(ram_rdata))
    else $error("payload read data lost while stalled");

endmodule

[rtl/mcfp_ram.sv]
module mcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mcfp_parser.sv]
module mcfp_parser
  import mcfp_pkg::*;
#(
  parameter int BUFFER_BYTES = MCFP_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] func,
  input  logic [7:0] rx_byte,
  input  logic [8:0] buffer_size,
  output result_t    res,
  output wr_req_t    wr
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [8:0] bs_r, bs_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [1:0] last_err_r, last_err_nxt;

  logic       take;
  logic       too_big;
  logic [8:0] bs_inc;
  logic       data_done;
  logic [8:0] wr_idx;
  logic       wr_in_range;

  assign take    = step && (func == FN_BYTE);
  assign too_big = (({2'b0, rx_byte} + 10'd3) > {1'b0, buffer_size})
                || ((32'(rx_byte) + 32'd3) > BUFFER_BYTES);
  assign bs_inc    = bs_r + 9'd1;
  assign data_done = {1'b0, bs_inc} >= (10'd3 + {2'b0, len_r});
  assign wr_idx      = bs_r - 9'd2;
  assign wr_in_range = (bs_r >= 9'd2) && (32'(wr_idx) < BUFFER_BYTES);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step && func == FN_TIMEOUT) begin
      phase_nxt = PH_IDLE;
    end else if (take) begin
      unique case (phase_r)
        PH_IDLE:    phase_nxt = (rx_byte == CH_DOLLAR) ? PH_HDR_M : PH_IDLE;
        PH_HDR_M:   phase_nxt = (rx_byte == CH_M) ? PH_HDR_DIR : PH_IDLE;
        PH_HDR_DIR: phase_nxt = (rx_byte == CH_LT) ? PH_LEN : PH_IDLE;
        PH_LEN:     phase_nxt = too_big ? PH_IDLE : PH_CMD;
        PH_CMD:     phase_nxt = PH_DATA;
        PH_DATA:    phase_nxt = data_done ? PH_IDLE : PH_DATA;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result, frame registers and payload write
  always_comb begin
    logic       fail;
    logic       clr_err;
    logic [1:0] fail_code;
    fail         = 1'b0;
    clr_err      = 1'b0;
    fail_code    = ERR_NONE;
    res          = '0;
    wr           = '0;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    bs_nxt       = bs_r;
    xor_nxt      = xor_r;
    last_err_nxt = last_err_r;
    if (take) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_byte != CH_DOLLAR) begin
            res.frame_kind  = FK_FOREIGN;
            res.passed_byte = rx_byte;
          end else begin
            clr_err = 1'b1;
          end
        end
        PH_HDR_M: begin
          fail      = (rx_byte != CH_M);
          fail_code = ERR_HEADER;
          clr_err   = !fail;
        end
        PH_HDR_DIR: begin
          fail      = (rx_byte != CH_LT);
          fail_code = ERR_HEADER;
          clr_err   = !fail;
        end
        PH_LEN: begin
          fail      = too_big;
          fail_code = ERR_BIG;
          clr_err   = !fail;
          if (!too_big) begin
            len_nxt = rx_byte;
            xor_nxt = rx_byte;
            bs_nxt  = 9'd1;
          end
        end
        PH_CMD: begin
          cmd_nxt = rx_byte;
          xor_nxt = xor_r ^ rx_byte;
          bs_nxt  = 9'd2;
          clr_err = 1'b1;
        end
        PH_DATA: begin
          wr.en   = wr_in_range;
          wr.idx  = wr_idx;
          wr.data = rx_byte;
          bs_nxt  = bs_inc;
          if (data_done) begin
            // checksum byte: a good frame keeps the error memory as it is
            fail      = (rx_byte != xor_r);
            fail_code = ERR_CRC;
            if (!fail) begin
              res.frame_kind     = FK_VALID;
              res.command        = cmd_r;
              res.payload_length = len_r;
            end
          end else begin
            xor_nxt = xor_r ^ rx_byte;
            clr_err = 1'b1;
          end
        end
        default: clr_err = 1'b1;
      endcase
      if (fail) begin
        res.error_code   = fail_code;
        res.error_is_new = (fail_code != last_err_r);
        last_err_nxt     = fail_code;
      end else if (clr_err) begin
        last_err_nxt = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      len_r      <= '0;
      cmd_r      <= '0;
      bs_r       <= '0;
      xor_r      <= '0;
      last_err_r <= ERR_NONE;
    end else begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      cmd_r      <= cmd_nxt;
      bs_r       <= bs_nxt;
      xor_r      <= xor_nxt;
      last_err_r <= last_err_nxt;
    end
  end

endmodule
